@@ rtl/tcg_pkg.sv @@
// Shared types and constants for the textured column texel generator.
// No dependencies; tcg_front, tcg_div and the top module refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package tcg_pkg;

	localparam int unsigned SCREEN_HEIGHT = 1024;
	localparam logic [8:0] MAX_TEX_DIM = 9'd256;
	localparam logic [26:0] ROW_OFFSET = 27'(SCREEN_HEIGHT * 128);

	// quotient bits of the texel row divide, and bits resolved per stage
	localparam int unsigned QB = 9;
	localparam int unsigned BPS = 3;
	localparam int unsigned DIV_STAGES = (QB + BPS - 1) / BPS;

	localparam logic [1:0] CFG_CEILING = 2'd0;
	localparam logic [1:0] CFG_FLOOR = 2'd1;
	localparam logic [1:0] CFG_TEX_W = 2'd2;
	localparam logic [1:0] CFG_TEX_H = 2'd3;

	localparam logic [1:0] KIND_CEILING = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_FLOOR = 2'd2;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_WEST = 2'd2;
	localparam logic [1:0] FACE_EAST = 2'd3;

	typedef struct packed {
		logic [31:0] ceiling;
		logic [31:0] floor;
		logic [8:0]  w;
		logic [8:0]  h;
	} cfg_t;

	// per-item fields that ride alongside the divider
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  face;
		logic [31:0] flat;
		logic [8:0]  col;
		logic [8:0]  w;
		logic [8:0]  h;
	} side_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [23:0] d;
		logic [8:0]  q;
		logic        ovf;
	} div_t;

endpackage
`default_nettype wire

@@ rtl/tcg_if.sv @@
// Channel interfaces: pixel request, pixel result, configuration write.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tcg_in_if;
	logic               valid;
	logic               ready;
	logic [9:0]         row;
	logic [10:0]        wall_top;
	logic [10:0]        wall_bottom;
	logic               hit_side;
	logic [23:0]        player_x;
	logic [23:0]        player_y;
	logic signed [18:0] ray_dir_x;
	logic signed [18:0] ray_dir_y;
	logic [25:0]        perp_distance;
	logic [23:0]        wall_cell_x;
	logic [23:0]        wall_cell_y;
	logic [15:0]        slice_height;
	modport source (output valid, row, wall_top, wall_bottom, hit_side, player_x, player_y,
		ray_dir_x, ray_dir_y, perp_distance, wall_cell_x, wall_cell_y, slice_height,
		input ready);
	modport sink (input valid, row, wall_top, wall_bottom, hit_side, player_x, player_y,
		ray_dir_x, ray_dir_y, perp_distance, wall_cell_x, wall_cell_y, slice_height,
		output ready);
endinterface

interface tcg_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  pixel_kind;
	logic [1:0]  face;
	logic [31:0] flat_color;
	logic [15:0] texel_index;
	modport source (output valid, pixel_kind, face, flat_color, texel_index, input ready);
	modport sink (input valid, pixel_kind, face, flat_color, texel_index, output ready);
endinterface

interface tcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/tcg_front.sv @@
// Front end, stages 1..3: classify, face, hit fraction, texture column, divide operands.
// Depends on tcg_pkg and tcg_in_if.
`timescale 1ns / 1ps
`default_nettype none
module tcg_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire tcg_pkg::cfg_t cfg,
	tcg_in_if.sink            pix,
	output logic              valid_s3,
	output tcg_pkg::side_t    side_s3,
	output tcg_pkg::div_t     div_s3
);

	// stage 1
	logic              valid_s1;
	logic [1:0]        kind_s1, face_s1;
	logic              mirror_s1;
	logic [31:0]       prod_s1;
	logic [15:0]       pos_s1;
	logic [23:0]       s_s1;
	logic [15:0]       wh_s1;
	tcg_pkg::cfg_t     cfg_s1;

	logic [15:0]        wh;
	logic signed [18:0] ray;
	logic [31:0]        prod;
	logic [26:0]        sval;
	logic [1:0]         kind, face;

	always_comb begin
		wh = (pix.slice_height == 16'd0) ? 16'd1 : pix.slice_height;
		ray = pix.hit_side ? pix.ray_dir_x : pix.ray_dir_y;
		// only the low 32 bits of the product reach the fraction
		prod = {6'd0, pix.perp_distance} * 32'(ray);
		sval = {9'd0, pix.row, 8'd0} + {4'd0, wh, 7'd0} - tcg_pkg::ROW_OFFSET;
		if ({1'b0, pix.row} < pix.wall_top) kind = tcg_pkg::KIND_CEILING;
		else if ({1'b0, pix.row} >= pix.wall_bottom) kind = tcg_pkg::KIND_FLOOR;
		else kind = tcg_pkg::KIND_WALL;
		if (pix.hit_side && pix.wall_cell_y < pix.player_y) face = tcg_pkg::FACE_NORTH;
		else if (pix.hit_side && pix.wall_cell_y > pix.player_y) face = tcg_pkg::FACE_SOUTH;
		else if (!pix.hit_side && pix.wall_cell_x < pix.player_x) face = tcg_pkg::FACE_WEST;
		else face = tcg_pkg::FACE_EAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= pix.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			face_s1 <= face;
			mirror_s1 <= (!pix.hit_side && pix.ray_dir_x < 0) ||
				(pix.hit_side && pix.ray_dir_y > 0);
			prod_s1 <= prod;
			pos_s1 <= pix.hit_side ? pix.player_x[15:0] : pix.player_y[15:0];
			// only a positive scaled row contributes
			s_s1 <= (!sval[26] && sval != 27'd0) ? sval[23:0] : 24'd0;
			wh_s1 <= wh;
			cfg_s1 <= cfg;
		end
	end

	// stage 2
	logic              valid_s2;
	logic [1:0]        kind_s2, face_s2;
	logic              mirror_s2;
	logic [40:0]       colw_s2;
	logic [32:0]       n_s2;
	logic [23:0]       d_s2;
	tcg_pkg::cfg_t     cfg_s2;
	logic [31:0]       frac;

	assign frac = {pos_s1, 16'd0} + prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			face_s2 <= face_s1;
			mirror_s2 <= mirror_s1;
			colw_s2 <= {9'd0, frac} * {32'd0, cfg_s1.w};
			n_s2 <= {9'd0, s_s1} * {24'd0, cfg_s1.h};
			d_s2 <= {wh_s1, 8'd0};
			cfg_s2 <= cfg_s1;
		end
	end

	// stage 3
	logic [8:0] col;
	assign col = colw_s2[40:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.kind <= kind_s2;
			side_s3.face <= face_s2;
			side_s3.flat <= (kind_s2 == tcg_pkg::KIND_CEILING) ? cfg_s2.ceiling :
				(kind_s2 == tcg_pkg::KIND_FLOOR) ? cfg_s2.floor : 32'd0;
			side_s3.col <= mirror_s2 ? (cfg_s2.w - 9'd1 - col) : col;
			side_s3.w <= cfg_s2.w;
			side_s3.h <= cfg_s2.h;
			div_s3.rem <= n_s2;
			div_s3.d <= d_s2;
			div_s3.q <= '0;
			// quotient at or beyond 512 always clamps
			div_s3.ovf <= n_s2 >= {d_s2, 9'd0};
		end
	end

endmodule
`default_nettype wire

@@ rtl/tcg_div.sv @@
// Pipelined restoring divider for the texel row, BPS quotient bits per stage.
// Depends on tcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcg_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_i,
	input  wire tcg_pkg::side_t side_i,
	input  wire tcg_pkg::div_t  div_i,
	output logic                valid_o,
	output tcg_pkg::side_t      side_o,
	output tcg_pkg::div_t       div_o
);

	logic           vld [1:tcg_pkg::DIV_STAGES];
	tcg_pkg::side_t sd  [1:tcg_pkg::DIV_STAGES];
	tcg_pkg::div_t  dv  [1:tcg_pkg::DIV_STAGES];

	for (genvar k = 0; k < tcg_pkg::DIV_STAGES; k++) begin : g_stage
		logic           vin;
		tcg_pkg::side_t sin;
		tcg_pkg::div_t  din;
		tcg_pkg::div_t  nxt;

		if (k == 0) begin : g_first
			assign vin = valid_i;
			assign sin = side_i;
			assign din = div_i;
		end else begin : g_next
			assign vin = vld[k];
			assign sin = sd[k];
			assign din = dv[k];
		end

		always_comb begin
			int sh;
			nxt = din;
			for (int j = 0; j < tcg_pkg::BPS; j++) begin
				if (k * tcg_pkg::BPS + j < tcg_pkg::QB) begin
					sh = tcg_pkg::QB - 1 - k * tcg_pkg::BPS - j;
					if (nxt.rem >= ({9'd0, nxt.d} << sh)) begin
						nxt.rem = nxt.rem - ({9'd0, nxt.d} << sh);
						nxt.q[sh] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[k+1] <= 1'b0;
			else if (en) vld[k+1] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd[k+1] <= sin;
				dv[k+1] <= nxt;
			end
		end
	end

	assign valid_o = vld[tcg_pkg::DIV_STAGES];
	assign side_o = sd[tcg_pkg::DIV_STAGES];
	assign div_o = dv[tcg_pkg::DIV_STAGES];

endmodule
`default_nettype wire

@@ rtl/textured_column_texel_generator.sv @@
// Pipeline: 3 front stages, 3 divide stages and 1 output register from accepted item to result valid.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Reset: pipeline empty, colors 0, texture size 64 x 64; config is always ready.
// Depends on tcg_pkg, tcg_if, tcg_front and tcg_div.
`timescale 1ns / 1ps
`default_nettype none
module textured_column_texel_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	tcg_in_if.sink    pix,
	tcg_out_if.source res,
	tcg_cfg_if.sink   cfg
);

	logic [31:0] ceiling_q, floor_q;
	logic [8:0]  tex_w_q, tex_h_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= 32'd0;
			floor_q <= 32'd0;
			tex_w_q <= 9'd64;
			tex_h_q <= 9'd64;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tcg_pkg::CFG_CEILING: ceiling_q <= cfg.data;
				tcg_pkg::CFG_FLOOR:   floor_q <= cfg.data;
				tcg_pkg::CFG_TEX_W:   tex_w_q <= cfg.data[8:0];
				tcg_pkg::CFG_TEX_H:   tex_h_q <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	tcg_pkg::cfg_t cfg_w;
	always_comb begin
		cfg_w.ceiling = ceiling_q;
		cfg_w.floor = floor_q;
		cfg_w.w = (tex_w_q == 9'd0) ? 9'd1 :
			(tex_w_q > tcg_pkg::MAX_TEX_DIM) ? tcg_pkg::MAX_TEX_DIM : tex_w_q;
		cfg_w.h = (tex_h_q == 9'd0) ? 9'd1 :
			(tex_h_q > tcg_pkg::MAX_TEX_DIM) ? tcg_pkg::MAX_TEX_DIM : tex_h_q;
	end

	logic en;
	logic valid_s7;
	assign en = !valid_s7 || res.ready;
	assign pix.ready = en;

	logic           valid_s3, valid_s6;
	tcg_pkg::side_t side_s3, side_s6;
	tcg_pkg::div_t  div_s3, div_s6;

	tcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_w),
		.pix      (pix),
		.valid_s3 (valid_s3),
		.side_s3  (side_s3),
		.div_s3   (div_s3)
	);

	tcg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (valid_s3),
		.side_i  (side_s3),
		.div_i   (div_s3),
		.valid_o (valid_s6),
		.side_o  (side_s6),
		.div_o   (div_s6)
	);

	// texel row clamp and index
	logic [8:0]  trow;
	logic [17:0] idx;
	logic        is_wall;

	always_comb begin
		trow = (div_s6.ovf || div_s6.q >= side_s6.h) ? side_s6.h - 9'd1 : div_s6.q;
		idx = {9'd0, side_s6.w} * {9'd0, trow} + {9'd0, side_s6.col};
		is_wall = side_s6.kind == tcg_pkg::KIND_WALL;
	end

	logic [1:0]  kind_s7, face_s7;
	logic [31:0] flat_s7;
	logic [15:0] idx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s7 <= 1'b0;
		else if (en) valid_s7 <= valid_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s7 <= side_s6.kind;
			face_s7 <= is_wall ? side_s6.face : tcg_pkg::FACE_NORTH;
			flat_s7 <= side_s6.flat;
			idx_s7 <= is_wall ? idx[15:0] : 16'd0;
		end
	end

	assign res.valid = valid_s7;
	assign res.pixel_kind = kind_s7;
	assign res.face = face_s7;
	assign res.flat_color = flat_s7;
	assign res.texel_index = idx_s7;

endmodule
`default_nettype wire
